@@ hdl/base64_stream_encoder_assert.svh @@
// Assertion macros shared by the Base64 encoder modules.
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define B64_ASSERT_IMPL(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, checked outside reset.
`define B64_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

@@ hdl/b64enc_pkg.sv @@
// Shared types, constants and the alphabet lookup for the Base64 encoder.
package b64enc_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] LAST_SLOT  = 2'd3;
    localparam logic [6:0] PAD_CHAR   = 7'h3D;
    localparam logic [6:0] CHAR_PLUS  = 7'h2B;
    localparam logic [6:0] CHAR_SLASH = 7'h2F;
    localparam logic [7:0] ZERO_PAD   = 8'h00;

    // One group of up to three bytes waiting to be serialised.
    typedef struct packed {
        logic [23:0] bits;        // first byte in bits 23..16
        logic [1:0]  real_bytes;  // bytes of real data, 1 to 3
        logic        last;        // group ends the message
    } group_t;

    // Map a six-bit value onto the standard alphabet.
    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] r;
        if (v < 6'd26)
            r = 7'd65 + {1'b0, v};
        else if (v < 6'd52)
            r = 7'd71 + {1'b0, v};
        else if (v < 6'd62)
            r = {1'b0, v} - 7'd4;
        else if (v == 6'd62)
            r = CHAR_PLUS;
        else
            r = CHAR_SLASH;
        return r;
    endfunction

endpackage

@@ hdl/b64enc_front.sv @@
// Front end: gathers bytes into groups and hands finished groups to the queue.
module b64enc_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] data_byte
    input  logic                   s_axis_tlast,   // end_of_message
    input  logic                   q_full,
    output logic                   q_push,
    output b64enc_pkg::group_t     q_group
);

    logic [15:0] held_bytes_reg, held_bytes_next;
    logic [1:0]  held_count_reg, held_count_next;
    logic        accept;
    logic        close_group;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        close_group     = s_axis_tlast || (held_count_reg == 2'd2);
        q_push          = accept && close_group;
        q_group.last    = s_axis_tlast;
        q_group.real_bytes = held_count_reg + 2'd1;
        case (held_count_reg)
            2'd0:    q_group.bits = {s_axis_tdata, b64enc_pkg::ZERO_PAD, b64enc_pkg::ZERO_PAD};
            2'd1:    q_group.bits = {held_bytes_reg[15:8], s_axis_tdata, b64enc_pkg::ZERO_PAD};
            default: q_group.bits = {held_bytes_reg, s_axis_tdata};
        endcase

        held_bytes_next = held_bytes_reg;
        held_count_next = held_count_reg;
        if (accept)
        begin
            if (close_group)
            begin
                held_bytes_next = 16'd0;
                held_count_next = 2'd0;
            end
            else
            begin
                if (held_count_reg == 2'd0)
                    held_bytes_next = {s_axis_tdata, 8'd0};
                else
                    held_bytes_next = {held_bytes_reg[15:8], s_axis_tdata};
                held_count_next = held_count_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_bytes_reg <= 16'd0;
            held_count_reg <= 2'd0;
        end
        else
        begin
            held_bytes_reg <= held_bytes_next;
            held_count_reg <= held_count_next;
        end
    end

endmodule

@@ hdl/b64enc_queue.sv @@
// Short register queue of groups between the front and back ends.
`include "base64_stream_encoder_assert.svh"

module b64enc_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  b64enc_pkg::group_t     wr_group,
    output logic                   full,
    input  logic                   pop,
    output logic                   head_valid,
    output b64enc_pkg::group_t     head
);

    localparam logic [b64enc_pkg::QUEUE_AW-1:0] LAST_PTR =
        b64enc_pkg::QUEUE_AW'(b64enc_pkg::QUEUE_DEPTH - 1);
    localparam logic [b64enc_pkg::QUEUE_CW-1:0] DEPTH_CNT =
        b64enc_pkg::QUEUE_CW'(b64enc_pkg::QUEUE_DEPTH);

    b64enc_pkg::group_t                  entry_reg [b64enc_pkg::QUEUE_DEPTH];
    logic [b64enc_pkg::QUEUE_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [b64enc_pkg::QUEUE_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [b64enc_pkg::QUEUE_CW-1:0]     count_reg, count_next;
    logic                                do_push;
    logic                                do_pop;

    assign full       = (count_reg == DEPTH_CNT);
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wr_group;
    end

    `B64_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !full)
    `B64_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= DEPTH_CNT)
    `B64_ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, head_valid)

endmodule

@@ hdl/b64enc_back.sv @@
// Back end: turns each queued group into four characters, one per cycle while m_axis is ready.
`include "base64_stream_encoder_assert.svh"

module b64enc_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  b64enc_pkg::group_t     head,
    output logic                   pop,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [7:0]             m_axis_tdata,   // [6:0] code_char, [7] zero
    output logic                   m_axis_tlast    // final_char
);

    logic [1:0] slot_reg, slot_next;
    logic       out_valid_reg, out_valid_next;
    logic [6:0] out_char_reg;
    logic       out_last_reg;
    logic       load;
    logic [5:0] sextet;
    logic [6:0] slot_char;
    logic       slot_last;

    always_comb
    begin
        load = head_valid && (!out_valid_reg || m_axis_tready);
        case (slot_reg)
            2'd0:    sextet = head.bits[23:18];
            2'd1:    sextet = head.bits[17:12];
            2'd2:    sextet = head.bits[11:6];
            default: sextet = head.bits[5:0];
        endcase
        // Slots beyond the real data carry padding.
        slot_char = (slot_reg <= head.real_bytes) ? b64enc_pkg::sextet_char(sextet)
                                                  : b64enc_pkg::PAD_CHAR;
        slot_last = head.last && (slot_reg == b64enc_pkg::LAST_SLOT);
        pop       = load && (slot_reg == b64enc_pkg::LAST_SLOT);

        slot_next      = load ? slot_reg + 2'd1 : slot_reg;
        out_valid_next = load ? 1'b1 : (out_valid_reg && !m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg <= slot_char;
            out_last_reg <= slot_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_char_reg};
    assign m_axis_tlast  = out_last_reg;

    `B64_ASSERT_IMPL(a_last_on_slot3, clk, rst_n, load && slot_last, pop)
    `B64_ASSERT_NEXT(a_pop_restarts, clk, rst_n, pop, slot_reg == 2'd0)

endmodule

@@ hdl/base64_stream_encoder.sv @@
// Top level of the streaming Base64 encoder: front end, group queue, back end.
//
//   channel      | direction | tdata                     | tlast          | tuser
//   -------------+-----------+---------------------------+----------------+------
//   s_axis       | in        | [7:0] data_byte           | end_of_message | none
//   m_axis       | out       | [6:0] code_char, [7] zero | final_char     | none
//
// Each group of three bytes, or a shorter one closed by tlast, becomes four characters;
// the back end sends one per cycle while m_axis_tready is high.
// The front end takes a byte each cycle while the two-entry group queue has room.
// A closed group is written into the queue; each character then passes the output register.
// rst_n clears the partial group, the queue and the output valid flag.
// An m_axis stall holds the output register; s_axis_tready drops while the queue is full.
module base64_stream_encoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] code_char, [7] zero
    output logic        m_axis_tlast    // final_char
);

    logic                q_full;
    logic                q_push;
    b64enc_pkg::group_t  q_group;
    logic                q_pop;
    logic                q_head_valid;
    b64enc_pkg::group_t  q_head;

    // Gather bytes and classify: hold a partial group or release one closed by a third byte or tlast.
    b64enc_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_group       (q_group)
    );

    // Decouple the two sides so either may stall on its own.
    b64enc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .wr_group   (q_group),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    // Serialise each group into characters through the output register.
    b64enc_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (q_head_valid),
        .head          (q_head),
        .pop           (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
